// File: design/ffmp_pkg.sv
// Shared types, constants and helper functions of the fuse filter membership probe.
package ffmp_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned LEN_W   = 17;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned FP_W    = 8;
  localparam int unsigned SLOT_W  = 32;
  localparam int unsigned HALF_W  = 32;
  localparam int unsigned CIDX_W  = 2;

  // Finaliser mix constants and shift distances.
  localparam logic [KEY_W-1:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [KEY_W-1:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned MIX_SHIFT  = 33;
  localparam int unsigned SLOT_SHIFT = 18;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_SEED     = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_SEG_LEN  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_SEG_SPAN = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_TBL_LEN  = 2'd3;

  // Input item kinds.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_PROBE = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] seed;
    logic [LEN_W-1:0] seg_len;
    logic [LEN_W-1:0] seg_span;
    logic [LEN_W-1:0] tbl_len;
  } cfg_t;

  typedef struct packed {
    logic [HALF_W-1:0] a;
    logic [HALF_W-1:0] b;
  } mul_op_t;

  // Folds the low 32 bits of the hash down to the 8-bit fingerprint.
  function automatic logic [FP_W-1:0] fold_byte(input logic [KEY_W-1:0] h);
    return h[7:0] ^ h[15:8] ^ h[23:16] ^ h[31:24];
  endfunction

  // One xor-shift step of the finaliser.
  function automatic logic [KEY_W-1:0] xor_shift(input logic [KEY_W-1:0] v);
    return v ^ (v >> MIX_SHIFT);
  endfunction

endpackage

// File: design/ffmp_mul.sv
// Shared 32 by 32 bit unsigned multiplier with a registered product.
module ffmp_mul (
  input  logic                          clk,
  input  ffmp_pkg::mul_op_t             op,
  output logic [2*ffmp_pkg::HALF_W-1:0] prod
);

  logic [2*ffmp_pkg::HALF_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= 64'(op.a) * 64'(op.b);
  end

  assign prod = prod_r;

endmodule

// File: design/ffmp_ram.sv
// Single-port fingerprint table with registered read data.
module ffmp_ram #(
  parameter int unsigned ADDR_W = 16
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         addr,
  input  logic [ffmp_pkg::FP_W-1:0] wdata,
  output logic [ffmp_pkg::FP_W-1:0] rdata
);

  logic [ffmp_pkg::FP_W-1:0] mem [2**ADDR_W];
  logic [ffmp_pkg::FP_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/ffmp_ctrl.sv
// Probe sequencer: table writes, hash mix, slot derivation, table reads and result register.
module ffmp_ctrl #(
  parameter int unsigned TABLE_DEPTH = 65536,
  parameter int unsigned ADDR_W      = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ffmp_pkg::cfg_t                  cfg,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic                            in_mode,
  input  logic [ffmp_pkg::IDX_W-1:0]      in_index,
  input  logic [ffmp_pkg::FP_W-1:0]       in_value,
  input  logic [ffmp_pkg::KEY_W-1:0]      in_key,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic                            out_present,
  output ffmp_pkg::mul_op_t               mul_op,
  input  logic [2*ffmp_pkg::HALF_W-1:0]   mul_prod,
  output logic                            ram_we,
  output logic [ADDR_W-1:0]               ram_addr,
  output logic [ffmp_pkg::FP_W-1:0]       ram_wdata,
  input  logic [ffmp_pkg::FP_W-1:0]       ram_rdata
);

  localparam int unsigned ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE = 4'd0;
  localparam logic [ST_W-1:0] S_XS   = 4'd1;
  localparam logic [ST_W-1:0] S_M0   = 4'd2;
  localparam logic [ST_W-1:0] S_M1   = 4'd3;
  localparam logic [ST_W-1:0] S_M2   = 4'd4;
  localparam logic [ST_W-1:0] S_M3   = 4'd5;
  localparam logic [ST_W-1:0] S_H0   = 4'd6;
  localparam logic [ST_W-1:0] S_H1   = 4'd7;
  localparam logic [ST_W-1:0] S_H2   = 4'd8;
  localparam logic [ST_W-1:0] S_SLOT = 4'd9;
  localparam logic [ST_W-1:0] S_RD0  = 4'd10;
  localparam logic [ST_W-1:0] S_RD1  = 4'd11;
  localparam logic [ST_W-1:0] S_RD2  = 4'd12;
  localparam logic [ST_W-1:0] S_RD3  = 4'd13;
  localparam logic [ST_W-1:0] S_FIN  = 4'd14;

  localparam int unsigned KW = ffmp_pkg::KEY_W;
  localparam int unsigned HW = ffmp_pkg::HALF_W;
  localparam int unsigned SW = ffmp_pkg::SLOT_W;
  localparam logic [SW:0] DEPTH_X = (SW+1)'(TABLE_DEPTH);

  logic [ST_W-1:0]             state_r, state_nxt;
  logic                        round_r, round_nxt;
  logic [KW-1:0]               h_r, h_nxt;
  logic [KW-1:0]               acc_r, acc_nxt;
  logic [SW-1:0]               s0_r, s0_nxt;
  logic [SW-1:0]               s1_r, s1_nxt;
  logic [SW-1:0]               s2_r, s2_nxt;
  logic                        ok_r, ok_nxt;
  logic [ffmp_pkg::FP_W-1:0]   fp_r, fp_nxt;
  logic                        res_r, res_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        present_r, present_nxt;

  logic [KW-1:0]               mix_c;
  logic [KW-1:0]               mix_sum;
  logic [KW-1:0]               hi_sum;
  logic [SW-1:0]               seg_len_w;
  logic [SW-1:0]               seg_mask;
  logic [SW-1:0]               wr_idx_w;
  logic [HW-1:0]               span_w;

  // A slot is usable only below both the configured length and the physical depth.
  function automatic logic slot_ok(input logic [SW-1:0] s, input logic [SW-1:0] len);
    return (s < len) && ({1'b0, s} < DEPTH_X);
  endfunction

  assign mix_c     = round_r ? ffmp_pkg::MIX_C2 : ffmp_pkg::MIX_C1;
  assign mix_sum   = {acc_r[KW-1:HW] + mul_prod[HW-1:0], acc_r[HW-1:0]};
  assign hi_sum    = acc_r + mul_prod;
  assign seg_len_w = SW'(cfg.seg_len);
  assign seg_mask  = seg_len_w - SW'(1);
  assign wr_idx_w  = SW'(in_index);
  assign span_w    = HW'(cfg.seg_span);

  always_comb begin
    state_nxt     = state_r;
    round_nxt     = round_r;
    h_nxt         = h_r;
    acc_nxt       = acc_r;
    s0_nxt        = s0_r;
    s1_nxt        = s1_r;
    s2_nxt        = s2_r;
    ok_nxt        = ok_r;
    fp_nxt        = fp_r;
    res_nxt       = res_r;
    present_nxt   = present_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    mul_op.a      = h_r[HW-1:0];
    mul_op.b      = mix_c[HW-1:0];
    ram_we        = 1'b0;
    ram_addr      = wr_idx_w[ADDR_W-1:0];
    ram_wdata     = in_value;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_mode == ffmp_pkg::MODE_PROBE) begin
            h_nxt     = in_key + cfg.seed;
            state_nxt = S_XS;
          end else begin
            ram_we = ({1'b0, wr_idx_w} < DEPTH_X);
          end
        end
      end
      S_XS: begin
        h_nxt     = ffmp_pkg::xor_shift(h_r);
        round_nxt = 1'b0;
        state_nxt = S_M0;
      end
      S_M0: begin
        mul_op.a  = h_r[HW-1:0];
        mul_op.b  = mix_c[HW-1:0];
        state_nxt = S_M1;
      end
      S_M1: begin
        acc_nxt   = mul_prod;
        mul_op.a  = h_r[KW-1:HW];
        mul_op.b  = mix_c[HW-1:0];
        state_nxt = S_M2;
      end
      S_M2: begin
        acc_nxt   = mix_sum;
        mul_op.a  = h_r[HW-1:0];
        mul_op.b  = mix_c[KW-1:HW];
        state_nxt = S_M3;
      end
      S_M3: begin
        h_nxt = ffmp_pkg::xor_shift(mix_sum);
        if (round_r) begin
          round_nxt = 1'b0;
          state_nxt = S_H0;
        end else begin
          round_nxt = 1'b1;
          state_nxt = S_M0;
        end
      end
      S_H0: begin
        mul_op.a  = h_r[HW-1:0];
        mul_op.b  = span_w;
        state_nxt = S_H1;
      end
      S_H1: begin
        acc_nxt   = {{HW{1'b0}}, mul_prod[KW-1:HW]};
        mul_op.a  = h_r[KW-1:HW];
        mul_op.b  = span_w;
        state_nxt = S_H2;
      end
      S_H2: begin
        s0_nxt    = hi_sum[KW-1:HW];
        state_nxt = S_SLOT;
      end
      S_SLOT: begin
        s1_nxt    = (s0_r + seg_len_w) ^ (h_r[ffmp_pkg::SLOT_SHIFT +: SW] & seg_mask);
        s2_nxt    = (s0_r + (seg_len_w << 1)) ^ (h_r[SW-1:0] & seg_mask);
        state_nxt = S_RD0;
      end
      S_RD0: begin
        ram_addr  = s0_r[ADDR_W-1:0];
        ok_nxt    = slot_ok(s0_r, SW'(cfg.tbl_len));
        state_nxt = S_RD1;
      end
      S_RD1: begin
        ram_addr  = s1_r[ADDR_W-1:0];
        fp_nxt    = ram_rdata;
        ok_nxt    = ok_r && slot_ok(s1_r, SW'(cfg.tbl_len));
        state_nxt = S_RD2;
      end
      S_RD2: begin
        ram_addr  = s2_r[ADDR_W-1:0];
        fp_nxt    = fp_r ^ ram_rdata;
        ok_nxt    = ok_r && slot_ok(s2_r, SW'(cfg.tbl_len));
        state_nxt = S_RD3;
      end
      S_RD3: begin
        ram_addr  = s2_r[ADDR_W-1:0];
        res_nxt   = ok_r && ((fp_r ^ ram_rdata) == ffmp_pkg::fold_byte(h_r));
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          present_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      round_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r       <= h_nxt;
    acc_r     <= acc_nxt;
    s0_r      <= s0_nxt;
    s1_r      <= s1_nxt;
    s2_r      <= s2_nxt;
    ok_r      <= ok_nxt;
    fp_r      <= fp_nxt;
    res_r     <= res_nxt;
    present_r <= present_nxt;
  end

  assign out_tvalid  = out_valid_r;
  assign out_present = present_r;

endmodule

// File: design/fuse_filter_membership_probe.sv
// Top level of the binary fuse filter membership probe with its configuration registers.
// A write transfer is absorbed in its accept cycle; writes can follow one per cycle while no probe runs.
// A probe result appears on out_tvalid when in_tready also returns, so the block takes no new
// item until the probe is through; one shared 32x32 multiplier (eight partial products) and
// three reads of the single-port table set a probe's length; an untaken result stalls the next probe.
// Synchronous reset (rst_n low) clears sequencer, output valid and configuration, not the table.
module fuse_filter_membership_probe #(
  parameter int unsigned TABLE_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // entry_index [15:0], entry_value [23:16], key_hash [87:24]
  input  logic        in_tuser,   // mode: 0 writes a table entry, 1 probes a key
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // maybe_present [0], zero padding [7:1]
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  // Table address width follows the depth of the fingerprint store.
  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);

  // Configuration registers. They are to be written only while the block is idle; the block does
  // not enforce this. Kept so, the sequencer can read them directly throughout a probe.
  ffmp_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ffmp_pkg::CFG_SEED:     cfg_nxt.seed     = cfg_wdata;
        ffmp_pkg::CFG_SEG_LEN:  cfg_nxt.seg_len  = cfg_wdata[ffmp_pkg::LEN_W-1:0];
        ffmp_pkg::CFG_SEG_SPAN: cfg_nxt.seg_span = cfg_wdata[ffmp_pkg::LEN_W-1:0];
        ffmp_pkg::CFG_TBL_LEN:  cfg_nxt.tbl_len  = cfg_wdata[ffmp_pkg::LEN_W-1:0];
        default:                cfg_nxt          = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ffmp_pkg::mul_op_t                    mul_op;
  logic [2*ffmp_pkg::HALF_W-1:0]        mul_prod;
  logic                                 ram_we;
  logic [ADDR_W-1:0]                    ram_addr;
  logic [ffmp_pkg::FP_W-1:0]            ram_wdata;
  logic [ffmp_pkg::FP_W-1:0]            ram_rdata;
  logic                                 present;

  // The sequencer walks each probe through the finaliser mix, the slot arithmetic and
  // the three table reads, reusing the one multiplier for every partial product.
  ffmp_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_mode     (in_tuser),
    .in_index    (in_tdata[15:0]),
    .in_value    (in_tdata[23:16]),
    .in_key      (in_tdata[87:24]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_present (present),
    .mul_op      (mul_op),
    .mul_prod    (mul_prod),
    .ram_we      (ram_we),
    .ram_addr    (ram_addr),
    .ram_wdata   (ram_wdata),
    .ram_rdata   (ram_rdata)
  );

  ffmp_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (mul_prod)
  );

  ffmp_ram #(
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_tdata = {7'b0, present};

endmodule
